// ===== sv/cpr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the camera point rotation block.
package cpr_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int ANGLE_WIDTH_DEF    = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] point_x;
    logic signed [COORD_WIDTH_DEF-1:0] point_y;
    logic signed [COORD_WIDTH_DEF-1:0] point_z;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] rotated_x;
    logic signed [COORD_WIDTH_DEF-1:0] rotated_y;
    logic signed [COORD_WIDTH_DEF-1:0] rotated_z;
  } point_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mat_status_t;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sh020000000;  5'd1: r = 34'sh012E4051E;
      5'd2: r = 34'sh009FB385B;  5'd3: r = 34'sh0051111D4;
      5'd4: r = 34'sh0028B0D43;  5'd5: r = 34'sh00145D7E1;
      5'd6: r = 34'sh000A2F61E;  5'd7: r = 34'sh000517C55;
      5'd8: r = 34'sh00028BE53;  5'd9: r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98; 5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6; 5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA; 5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE; 5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30; 5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C; 5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3; 5'd23: r = 34'sh000000051;
      5'd24: r = 34'sh000000029; 5'd25: r = 34'sh000000014;
      5'd26: r = 34'sh00000000A; 5'd27: r = 34'sh000000005;
      5'd28: r = 34'sh000000003; 5'd29: r = 34'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cpr_matrix.sv =====
// Matrix builder: CORDIC sine/cosine and a sequenced multiply unit that rebuilds the matrix.
module cpr_matrix #(
  parameter int ANGLE_WIDTH    = cpr_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = cpr_pkg::TRIG_FRAC_BITS_DEF,
  parameter int MW             = TRIG_FRAC_BITS + 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ANGLE_WIDTH-1:0]              yaw,
  input  logic [ANGLE_WIDTH-1:0]              pitch,
  output logic signed [8:0][MW-1:0]           mat,
  output cpr_pkg::mat_status_t                status
);
  import cpr_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;   // trig values, |v| <= 2^F
  localparam int PW = 2 * TW + 4;           // products
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< TRIG_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [TW+3:0] LIM = (TW+4)'(1) <<< (TRIG_FRAC_BITS + 2);

  typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_MUL, S_DONE} state_t;

  state_t state;
  logic       which;            // 0 yaw, 1 pitch
  logic [4:0] step;
  logic [3:0] mstep;
  logic signed [33:0] cx, cyv, cz;
  logic       neg;
  logic signed [TW-1:0] sy, cy, sp, cp;
  logic signed [TW+3:0] t0, t1, t2, p00, p02, p22;

  // CORDIC iteration and quadrant fold
  logic signed [33:0] dx, dy;
  logic signed [34:0] rx, ry;
  logic signed [TW-1:0] ox, oy;

  always_comb begin
    dx = cyv >>> step;
    dy = cx >>> step;
    rx = (35'(cx) + (35'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    ry = (35'(cyv) + (35'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    ox = (rx > 35'(ONE)) ? ONE : ((rx < -35'(ONE)) ? -ONE : TW'(rx));
    oy = (ry > 35'(ONE)) ? ONE : ((ry < -35'(ONE)) ? -ONE : TW'(ry));
    if (neg) begin
      ox = -ox;
      oy = -oy;
    end
  end

  // Shared multiplier: one product per step, rounded half up to QF.
  logic signed [TW+3:0] ma, mb;
  logic signed [PW-1:0] prod, madd;
  logic signed [TW+3:0] mq, omc;

  function automatic logic signed [MW-1:0] clampm(input logic signed [PW-1:0] v);
    if (v > PW'(LIM - 1)) return MW'(LIM - 1);
    if (v < -PW'(LIM)) return MW'(-LIM);
    return MW'(v);
  endfunction

  always_comb begin
    omc = (TW+4)'(ONE) - (TW+4)'(cp);
    ma = '0;
    mb = '0;
    madd = '0;
    unique case (mstep)
      4'd0: begin ma = cy; mb = cy; end
      4'd1: begin ma = t0; mb = omc; end
      4'd2: begin ma = cy; mb = sy; end
      4'd3: begin ma = t1; mb = omc; end
      4'd4: begin ma = sy; mb = sy; end
      4'd5: begin ma = t2; mb = omc; end
      4'd6: begin ma = sy; mb = sp; end
      4'd7: begin ma = cy; mb = sp; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = PW'(ma) * PW'(mb);
    madd = prod + HALF;
    mq = (TW+4)'(madd >>> TRIG_FRAC_BITS);
  end

  // Final rows 0 and 2: plain combinational over fixed entries once P is known.
  logic signed [TW+3:0] pm [3][3];
  always_comb begin
    pm[0][0] = (TW+4)'(cp) + p00;
    pm[0][1] = -t0;
    pm[0][2] = p02;
    pm[1][0] = t0;
    pm[1][1] = (TW+4)'(cp);
    pm[1][2] = -t1;
    pm[2][0] = p02;
    pm[2][1] = t1;
    pm[2][2] = (TW+4)'(cp) + p22;
  end

  logic [1:0] col;
  logic signed [PW-1:0] r0, r2;
  always_comb begin
    col = 2'(mstep - 4'd8);
    r0 = (PW'(cy) * PW'(pm[0][col]) + PW'(sy) * PW'(pm[2][col]) + HALF) >>> TRIG_FRAC_BITS;
    r2 = (PW'(cy) * PW'(pm[2][col]) - PW'(sy) * PW'(pm[0][col]) + HALF) >>> TRIG_FRAC_BITS;
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      which <= 1'b0;
      step <= '0;
      mstep <= '0;
      for (int k = 0; k < 9; k++)
        mat[k] <= (k == 0 || k == 4 || k == 8) ? MW'(ONE) : '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CORDIC;
            which <= 1'b0;
            step <= '0;
            neg <= (yaw[ANGLE_WIDTH-1] ^ yaw[ANGLE_WIDTH-2]);
            cx <= CORDIC_GAIN;
            cyv <= '0;
            cz <= 34'($signed(32'({yaw, {(32 - ANGLE_WIDTH){1'b0}}} +
                  ((yaw[ANGLE_WIDTH-1] ^ yaw[ANGLE_WIDTH-2]) ? 32'h80000000 : 32'h0))));
          end
        end
        S_CORDIC: begin
          if (step == 5'(CORDIC_STEPS)) begin
            if (!which) begin
              cy <= ox;
              sy <= oy;
              which <= 1'b1;
              step <= '0;
              neg <= (pitch[ANGLE_WIDTH-1] ^ pitch[ANGLE_WIDTH-2]);
              cx <= CORDIC_GAIN;
              cyv <= '0;
              cz <= 34'($signed(32'({pitch, {(32 - ANGLE_WIDTH){1'b0}}} +
                    ((pitch[ANGLE_WIDTH-1] ^ pitch[ANGLE_WIDTH-2]) ? 32'h80000000 : 32'h0))));
            end else begin
              cp <= ox;
              sp <= oy;
              state <= S_MUL;
              mstep <= '0;
            end
          end else begin
            if (!cz[33]) begin
              cx <= cx - dx;
              cyv <= cyv + dy;
              cz <= cz - atan_turn(step);
            end else begin
              cx <= cx + dx;
              cyv <= cyv - dy;
              cz <= cz + atan_turn(step);
            end
            step <= step + 5'd1;
          end
        end
        S_MUL: begin
          unique case (mstep)
            4'd0: t0 <= mq;
            4'd1: p00 <= mq;
            4'd2: t1 <= mq;
            4'd3: p02 <= mq;
            4'd4: t2 <= mq;
            4'd5: p22 <= mq;
            4'd6: t0 <= mq;   // sy*sp
            4'd7: t1 <= mq;   // cy*sp
            4'd8, 4'd9, 4'd10: begin
              mat[col]     <= clampm(r0);
              mat[3 + col] <= clampm(PW'(pm[1][col]));
              mat[6 + col] <= clampm(r2);
            end
            default: ;
          endcase
          if (mstep == 4'd10) state <= S_DONE;
          mstep <= mstep + 4'd1;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/cpr_front.sv =====
// Front end: takes items and holds them in a short queue for the back end.
module cpr_front #(
  parameter int DEPTH       = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  cpr_pkg::point_in_t   data_in,
  output logic                 q_valid,
  input  logic                 q_take,
  output cpr_pkg::point_in_t   q_data
);
  import cpr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  point_in_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;
  logic           wr_en, rd_en;

  assign full    = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= data_in;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + AW'(1);
      if (rd_en) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

// ===== sv/cpr_back.sv =====
// Back end: three-stage matrix-vector pipeline with round, saturate and output queue.
module cpr_back #(
  parameter int TRIG_FRAC_BITS = cpr_pkg::TRIG_FRAC_BITS_DEF,
  parameter int MW             = TRIG_FRAC_BITS + 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_take,
  input  cpr_pkg::point_in_t          in_data,
  input  logic signed [8:0][MW-1:0]   mat,
  output logic                        empty,
  input  logic                        pop,
  output cpr_pkg::point_out_t         data_out
);
  import cpr_pkg::*;

  localparam int COORD_WIDTH = COORD_WIDTH_DEF;
  localparam int PRW = COORD_WIDTH + MW;
  localparam int SW  = PRW + 2;
  localparam int OQ  = 4;
  localparam logic signed [SW-1:0] MAXV = SW'((65'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] RND  = SW'(1) <<< (TRIG_FRAC_BITS - 1);

  // Output queue sized to hold everything in flight.
  point_out_t   oq [OQ];
  logic [1:0]   owp, orp;
  logic [2:0]   ocnt;
  logic [1:0]   inflight;
  logic         v1, v2;
  logic signed [8:0][PRW-1:0] pr;
  logic signed [2:0][SW-1:0]  sum;

  assign in_take = in_valid && ({1'b0, ocnt} + 4'(inflight) < 4'(OQ));
  assign inflight = 2'(v1) + 2'(v2);
  assign empty = (ocnt == '0);
  assign data_out = oq[orp];

  logic signed [COORD_WIDTH-1:0] pv [3];
  always_comb begin
    pv[0] = in_data.point_x;
    pv[1] = in_data.point_y;
    pv[2] = in_data.point_z;
  end

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + RND) >>> TRIG_FRAC_BITS;
    if (r > MAXV) return COORD_WIDTH'(MAXV);
    if (r < -MAXV - 1) return COORD_WIDTH'(-MAXV - 1);
    return COORD_WIDTH'(r);
  endfunction

  logic pop_ok;
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    // stage 1: nine products; an element of a packed array is unsigned, so re-sign it
    for (int k = 0; k < 9; k++)
      pr[k] <= PRW'($signed(mat[k])) * PRW'(pv[k % 3]);
    // stage 2: row sums
    for (int i = 0; i < 3; i++)
      sum[i] <= SW'($signed(pr[3*i])) + SW'($signed(pr[3*i+1])) +
                SW'($signed(pr[3*i+2]));
    if (v2) oq[owp] <= '{rotated_x: sat(sum[0]), rotated_y: sat(sum[1]), rotated_z: sat(sum[2])};
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      owp <= '0;
      orp <= '0;
      ocnt <= '0;
    end else begin
      v1 <= in_take;
      v2 <= v1;
      if (v2) owp <= owp + 2'd1;
      if (pop_ok) orp <= orp + 2'd1;
      ocnt <= ocnt + 3'(v2) - 3'(pop_ok);
    end
  end
endmodule

// ===== sv/camera_point_rotate_core.sv =====
// Top level of the camera point rotation block.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  input   | push / full          | in  (point_x, point_y, point_z)
//  result  | pop / empty          | out (rotated_x, rotated_y, rotated_z)
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while results are popped; an accepted item goes from the
// input queue through the product stage and the sum stage into the output queue.
// A write to yaw or pitch rebuilds the matrix: two CORDIC runs, then eleven steps of
// the multiply sequence; cfg_ready is low meanwhile.
// Reset leaves both angles zero and the matrix at identity.
// Full rises only when the input queue fills behind a stalled result side.
module camera_point_rotate_core #(
  parameter int ANGLE_WIDTH    = cpr_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = cpr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  cpr_pkg::point_in_t           in,
  output logic                         empty,
  input  logic                         pop,
  output cpr_pkg::point_out_t          out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ANGLE_WIDTH-1:0]       cfg_data
);
  import cpr_pkg::*;

  localparam int MW = TRIG_FRAC_BITS + 3;

  logic [ANGLE_WIDTH-1:0] yaw, pitch;
  logic                   start;
  logic signed [8:0][MW-1:0] mat;
  mat_status_t            mst;
  logic                   qv, qt;
  point_in_t              qd;

  // Hold writes while the matrix is being rebuilt.
  assign cfg_ready = !mst.busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw <= '0;
      pitch <= '0;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_YAW: begin yaw <= cfg_data; start <= 1'b1; end
          REG_PITCH: begin pitch <= cfg_data; start <= 1'b1; end
          default: ;  // drop writes to unknown registers
        endcase
      end
    end
  end

  cpr_matrix #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .MW(MW)) u_mat (
    .clk(clk), .rst(rst), .start(start), .yaw(yaw), .pitch(pitch), .mat(mat), .status(mst)
  );

  cpr_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_in(in),
    .q_valid(qv), .q_take(qt), .q_data(qd)
  );

  cpr_back #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .MW(MW)) u_back (
    .clk(clk), .rst(rst), .in_valid(qv), .in_take(qt), .in_data(qd), .mat(mat),
    .empty(empty), .pop(pop), .data_out(out)
  );
endmodule

// ===== sv/cpr_checker.sv =====
// Port-level checker for the camera point rotation block, bound to the top level.
module cpr_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic [cpr_pkg::CFG_IDX_W-1:0] cfg_index
);
  import cpr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_YAW || cfg_index == REG_PITCH))
      |=> !cfg_ready)
    else $error("config accepted during rebuild");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting item vanished without a pop");
endmodule

bind camera_point_rotate_core cpr_checker u_chk (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the camera point rotation core.
`timescale 1ns / 100ps

module testbench;
  import cpr_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 12;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Arctangent table in turns, 2^32 per turn.
  localparam longint ATAN_TURNS [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // Scoreboard: holds its own copy of the angles and the cached matrix, and the
  // rotated points still owed by the block.
  class rotation_scoreboard;
    longint     mat [3][3];
    logic [15:0] yaw, pitch;
    point_out_t rotated_q[$];
    int         errors;

    function new();
      yaw = '0;
      pitch = '0;
      errors = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mat[i][j] = (i == j) ? 64'sd65536 : 64'sd0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
    endfunction

    // CORDIC sine and cosine in Q1.16.
    function void sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
      logic [31:0] t;
      logic        neg;
      longint      x, y, z, dx, dy;
      t = {ang, 16'h0};
      neg = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
      if (neg) t = t + 32'h80000000;
      z = longint'($signed(t));
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
        end else begin
          x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
        end
      end
      x = clamp((x + 64'sd8192) >>> 14, -64'sd65536, 64'sd65536);
      y = clamp((y + 64'sd8192) >>> 14, -64'sd65536, 64'sd65536);
      cs = neg ? -x : x;
      sn = neg ? -y : y;
    endfunction

    function void rebuild_matrix();
      longint sy, cy, sp, cp, omc, r0, r2;
      longint p [3][3];
      longint lim;
      lim = 64'sd1 << 18;
      sin_cos(yaw, sy, cy);
      sin_cos(pitch, sp, cp);
      omc = 64'sd65536 - cp;
      p[0][0] = cp + mulq(mulq(cy, cy), omc);
      p[0][1] = -mulq(sy, sp);
      p[0][2] = mulq(mulq(cy, sy), omc);
      p[1][0] = mulq(sy, sp);
      p[1][1] = cp;
      p[1][2] = -mulq(cy, sp);
      p[2][0] = p[0][2];
      p[2][1] = mulq(cy, sp);
      p[2][2] = cp + mulq(mulq(sy, sy), omc);
      for (int j = 0; j < 3; j++) begin
        r0 = (cy * p[0][j] + sy * p[2][j] + 64'sd32768) >>> 16;
        r2 = (-sy * p[0][j] + cy * p[2][j] + 64'sd32768) >>> 16;
        mat[0][j] = clamp(r0, -lim, lim - 1);
        mat[1][j] = clamp(p[1][j], -lim, lim - 1);
        mat[2][j] = clamp(r2, -lim, lim - 1);
      end
    endfunction

    // Note an accepted register write; spare indexes leave the matrix alone.
    function void write_angle(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_YAW) yaw = val;
      else if (idx == REG_PITCH) pitch = val;
      else return;
      rebuild_matrix();
    endfunction

    // Note an accepted point and queue its rotated image.
    function void note_point(point_in_t pt);
      longint     c [3];
      longint     s;
      point_out_t r;
      logic signed [31:0] res [3];
      c[0] = longint'(pt.point_x);
      c[1] = longint'(pt.point_y);
      c[2] = longint'(pt.point_z);
      for (int i = 0; i < 3; i++) begin
        s = mat[i][0] * c[0] + mat[i][1] * c[1] + mat[i][2] * c[2];
        s = (s + 64'sd32768) >>> 16;
        res[i] = 32'(clamp(s, -64'sd2147483648, 64'sd2147483647));
      end
      r.rotated_x = res[0];
      r.rotated_y = res[1];
      r.rotated_z = res[2];
      rotated_q.push_back(r);
    endfunction

    function void check_result(point_out_t got);
      point_out_t want;
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d z=%0d", $time,
                 got.rotated_x, got.rotated_y, got.rotated_z);
        errors++;
        return;
      end
      want = rotated_q.pop_front();
      if (got.rotated_x !== want.rotated_x) begin
        $display("%0t: rotated_x expected %0d actual %0d", $time, want.rotated_x,
                 got.rotated_x);
        errors++;
      end
      if (got.rotated_y !== want.rotated_y) begin
        $display("%0t: rotated_y expected %0d actual %0d", $time, want.rotated_y,
                 got.rotated_y);
        errors++;
      end
      if (got.rotated_z !== want.rotated_z) begin
        $display("%0t: rotated_z expected %0d actual %0d", $time, want.rotated_z,
                 got.rotated_z);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  point_in_t            in = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  point_out_t           out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  rotation_scoreboard sb = new();

  // Idle percentages for the sender and the receiver; changed per third of the run.
  int send_idle_pct = 16;
  int recv_idle_pct = 45;
  int points_sent = 0;
  int idle_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  camera_point_rotate_core dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in(in),
    .empty(empty), .pop(pop), .out(out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver: drop pop at random in the configured share of cycles.
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor: values seen here are those before the edge.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out);
  end

  // Watchdog: count cycles in which no handshake completes.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Pick a coordinate: full range, small values near the origin, or the extremes.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(2097151)) - 32'sd1048576;
      7:          return 32'sh7FFFFFFF;
      8:          return 32'sh80000000;
      default:    return $signed($urandom_range(4)) - 32'sd2;
    endcase
  endfunction

  // Hold push until the item is taken, then maybe leave a gap.
  task automatic send_point(input point_in_t pt);
    int third;
    push <= 1'b1;
    in <= pt;
    do @(posedge clk); while (full);
    sb.note_point(pt);
    points_sent++;
    third = points_sent / 215;
    if (third == 1) begin
      send_idle_pct = 45;
      recv_idle_pct = 16;
    end else if (third >= 2) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_coords(input logic signed [31:0] x, y, z);
    point_in_t pt;
    pt.point_x = x;
    pt.point_y = y;
    pt.point_z = z;
    send_point(pt);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_coords(pick_coord(), pick_coord(), pick_coord());
  endtask

  // Drain all owed items, let the pipeline settle, then write one register and
  // wait for the rebuild to finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    push <= 1'b0;
    do @(posedge clk); while (sb.rotated_q.size() != 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_angle(idx, val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'(16'h4000 * $urandom_range(3));
      3:       return 16'(16'h8000 + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity matrix straight out of reset: extremes pass through unchanged.
    send_coords(32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
    send_coords(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_coords(32'sd1, -32'sd1, 32'sd65536);
    send_coords(32'sh0000FFFF, 32'shFFFF0000, 32'sh55555555);
    send_coords(32'shAAAAAAAA, 32'sh12345678, -32'sd65536);
    send_coords(32'sd0, 32'sd0, 32'sd0);

    // Quarter turns, half turns and the top of the angle range.
    write_reg(REG_YAW, 16'h4000);
    send_coords(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_coords(32'sd65536, 32'sd0, -32'sd65536);
    write_reg(REG_PITCH, 16'h4000);
    send_coords(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_coords(32'sd65536, 32'sd65536, 32'sd65536);
    write_reg(REG_YAW, 16'h8000);
    write_reg(REG_PITCH, 16'h8000);
    send_coords(32'sh7FFFFFFF, 32'sh80000000, 32'sd12345);
    send_coords(-32'sd1, 32'sd1, 32'sd0);
    write_reg(REG_YAW, 16'hC000);
    write_reg(REG_PITCH, 16'hFFFF);
    send_coords(32'sh7FFFFFFF, 32'sd0, 32'sh80000000);
    send_coords(32'sd65536, -32'sd65536, 32'sd65536);
    write_reg(REG_YAW, 16'hFFFF);
    write_reg(REG_PITCH, 16'h2000);
    send_coords(32'sh40000000, 32'shC0000000, 32'sh7FFFFFFF);
    send_coords(32'sd98304, 32'sd0, -32'sd32768);

    // Spare indexes: the write is dropped and the matrix kept.
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hFFFF);
    send_coords(32'sh7FFFFFFF, 32'sd65536, -32'sd65536);
    send_coords(32'sd1000000, -32'sd2000000, 32'sd3000000);

    // Random phases with a new setting in between.
    while (points_sent < 620) begin
      case ($urandom_range(5))
        0:       write_reg(REG_YAW, pick_angle());
        1:       write_reg(REG_PITCH, pick_angle());
        2:       write_reg(CFG_IDX_W'($urandom_range(3)), pick_angle());
        default: begin
          write_reg(REG_YAW, pick_angle());
          write_reg(REG_PITCH, pick_angle());
        end
      endcase
      send_random($urandom_range(20, 60));
    end
    push <= 1'b0;

    // Drain, then give the pipeline time to show anything stray.
    do @(posedge clk); while (sb.rotated_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== camera_point_rotate_core.f =====
sv/cpr_pkg.sv
sv/cpr_matrix.sv
sv/cpr_front.sv
sv/cpr_back.sv
sv/camera_point_rotate_core.sv
sv/cpr_checker.sv
verif/testbench.sv
